// ===== rtl/assert_macros.svh =====
// Assertion shorthands; clocked on clk, quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/i2cbm_pkg.sv =====
package i2cbm_pkg;

  localparam int DATA_BITS     = 8;
  localparam int DELAY_W       = 24;
  localparam int CNT_W         = 4;
  localparam int CMD_W         = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int TPM_W         = 16;
  localparam int TIMEOUT_W     = 8;
  localparam int DELAY_UNIT_WIDTH_DEF = 16;

  localparam logic [DELAY_W-1:0]   DELAY_MAX     = 24'hFFFFFF;
  localparam logic [TPM_W-1:0]     TPM_RESET     = 16'd50;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;

  // command codes
  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TPM     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_A, PH_ST_B,
    PH_SP_A, PH_SP_B,
    PH_WR_SETUP, PH_WR_HIGH, PH_WR_LOW,
    PH_WA_A, PH_WA_B, PH_WA_POLL,
    PH_RD_LOW, PH_RD_HIGH,
    PH_RA_LOW, PH_RA_HIGH
  } phase_t;

  typedef struct packed {
    logic [TPM_W-1:0]     tpm;
    logic [TIMEOUT_W-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic                 cmd_valid;
    logic [CMD_W-1:0]     cmd;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 ack_after_read;
    logic                 sda_in;
  } item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy;
    logic                 done;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 ack_missing;
  } result_t;

endpackage

// ===== rtl/i2cbm_cfg_regs.sv =====
module i2cbm_cfg_regs
  import i2cbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tpm         <= TPM_RESET;
      cfg.ack_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TPM:     cfg.tpm         <= cfg_data[TPM_W-1:0];
        REG_TIMEOUT: cfg.ack_timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/i2cbm_sequencer.sv =====
module i2cbm_sequencer
  import i2cbm_pkg::*;
#(
  parameter int DELAY_UNIT_WIDTH = DELAY_UNIT_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int PW = DELAY_UNIT_WIDTH + 3;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     bit_count, bit_count_next;
  logic [DATA_BITS-1:0] shift_byte, shift_byte_next;
  logic [DELAY_W-1:0]   delay_count, delay_count_next;
  logic [TIMEOUT_W-1:0] ack_wait_count, ack_wait_count_next;
  logic                 scl_reg, scl_reg_next;
  logic                 sda_reg, sda_reg_next;
  logic                 sda_drive_reg, sda_drive_reg_next;
  logic [DATA_BITS-1:0] received_byte, received_byte_next;
  logic                 ack_error, ack_error_next;
  logic                 ack_latch, ack_latch_next;
  logic                 done;

  logic [DELAY_UNIT_WIDTH+TPM_W-1:0] tpm_wide;
  logic [PW-1:0]        unit_w;
  logic [DELAY_W-1:0]   d1, d2, d4, d5;
  logic [CNT_W-1:0]     bit_inc;

  function automatic logic [DELAY_W-1:0] sat_delay(input logic [PW-1:0] prod);
    logic [PW+DELAY_W-1:0] wide;
    wide = {{DELAY_W{1'b0}}, prod};
    if (wide > (PW+DELAY_W)'(DELAY_MAX)) return DELAY_MAX;
    else if (prod == '0) return DELAY_W'(1);
    else return wide[DELAY_W-1:0];
  endfunction

  // Delay unit masked to the configured width, then the four phase lengths.
  assign tpm_wide = {{DELAY_UNIT_WIDTH{1'b0}}, cfg.tpm};
  assign unit_w   = PW'(tpm_wide[DELAY_UNIT_WIDTH-1:0]);
  assign d1 = sat_delay(unit_w);
  assign d2 = sat_delay(unit_w << 1);
  assign d4 = sat_delay(unit_w << 2);
  assign d5 = sat_delay((unit_w << 2) + unit_w);
  assign bit_inc = bit_count + CNT_W'(1);

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    delay_count_next    = delay_count;
    ack_wait_count_next = ack_wait_count;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    sda_drive_reg_next  = sda_drive_reg;
    received_byte_next  = received_byte;
    ack_error_next      = ack_error;
    ack_latch_next      = ack_latch;
    done                = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        case (item.cmd)
          CMD_START: begin
            sda_drive_reg_next = 1'b1;
            sda_reg_next       = 1'b1;
            scl_reg_next       = 1'b1;
            delay_count_next   = d4;
            phase_next         = PH_ST_A;
          end
          CMD_STOP: begin
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b0;
            sda_reg_next       = 1'b0;
            delay_count_next   = d5;
            phase_next         = PH_SP_A;
          end
          CMD_WRITE: begin
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b0;
            bit_count_next     = '0;
            sda_reg_next       = item.tx_byte[DATA_BITS-1];
            shift_byte_next    = item.tx_byte << 1;
            delay_count_next   = d2;
            phase_next         = PH_WR_SETUP;
          end
          CMD_WACK: begin
            sda_drive_reg_next  = 1'b0;
            sda_reg_next        = 1'b1;
            ack_wait_count_next = '0;
            delay_count_next    = d1;
            phase_next          = PH_WA_A;
          end
          CMD_READ: begin
            sda_drive_reg_next = 1'b0;
            sda_reg_next       = 1'b1;
            scl_reg_next       = 1'b0;
            shift_byte_next    = '0;
            bit_count_next     = '0;
            ack_latch_next     = item.ack_after_read;
            delay_count_next   = d2;
            phase_next         = PH_RD_LOW;
          end
          default: ;
        endcase
      end
    end else if (phase != PH_WA_POLL && delay_count > DELAY_W'(1)) begin
      delay_count_next = delay_count - DELAY_W'(1);
    end else begin
      case (phase)
        PH_ST_A: begin
          sda_reg_next     = 1'b0;
          delay_count_next = d4;
          phase_next       = PH_ST_B;
        end
        PH_ST_B: begin
          scl_reg_next = 1'b0;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end
        PH_SP_A: begin
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = d5;
          phase_next       = PH_SP_B;
        end
        PH_SP_B: begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        PH_WR_SETUP: begin
          scl_reg_next     = 1'b1;
          delay_count_next = d2;
          phase_next       = PH_WR_HIGH;
        end
        PH_WR_HIGH: begin
          scl_reg_next     = 1'b0;
          delay_count_next = d2;
          phase_next       = PH_WR_LOW;
        end
        PH_WR_LOW: begin
          bit_count_next = bit_inc;
          if (bit_inc >= CNT_W'(DATA_BITS)) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            sda_reg_next     = shift_byte[DATA_BITS-1];
            shift_byte_next  = shift_byte << 1;
            delay_count_next = d2;
            phase_next       = PH_WR_SETUP;
          end
        end
        PH_WA_A: begin
          scl_reg_next     = 1'b1;
          delay_count_next = d1;
          phase_next       = PH_WA_B;
        end
        PH_WA_B, PH_WA_POLL: begin
          phase_next = PH_WA_POLL;
          if (!item.sda_in) begin
            scl_reg_next   = 1'b0;
            ack_error_next = 1'b0;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end else if (ack_wait_count == cfg.ack_timeout) begin
            // timed out: flag it and drop into a stop
            ack_error_next     = 1'b1;
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b0;
            sda_reg_next       = 1'b0;
            delay_count_next   = d5;
            phase_next         = PH_SP_A;
          end else begin
            ack_wait_count_next = ack_wait_count + TIMEOUT_W'(1);
          end
        end
        PH_RD_LOW: begin
          scl_reg_next     = 1'b1;
          shift_byte_next  = {shift_byte[DATA_BITS-2:0], item.sda_in};
          delay_count_next = d1;
          phase_next       = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          bit_count_next   = bit_inc;
          scl_reg_next     = 1'b0;
          delay_count_next = d2;
          if (bit_inc < CNT_W'(DATA_BITS)) begin
            phase_next = PH_RD_LOW;
          end else begin
            sda_drive_reg_next = 1'b1;
            sda_reg_next       = !ack_latch;
            phase_next         = PH_RA_LOW;
          end
        end
        PH_RA_LOW: begin
          scl_reg_next     = 1'b1;
          delay_count_next = d2;
          phase_next       = PH_RA_HIGH;
        end
        PH_RA_HIGH: begin
          scl_reg_next       = 1'b0;
          received_byte_next = shift_byte;
          phase_next         = PH_IDLE;
          done               = 1'b1;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shift_byte     <= '0;
      delay_count    <= '0;
      ack_wait_count <= '0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      sda_drive_reg  <= 1'b1;
      received_byte  <= '0;
      ack_error      <= 1'b0;
      ack_latch      <= 1'b0;
    end else if (step_en) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      delay_count    <= delay_count_next;
      ack_wait_count <= ack_wait_count_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      sda_drive_reg  <= sda_drive_reg_next;
      received_byte  <= received_byte_next;
      ack_error      <= ack_error_next;
      ack_latch      <= ack_latch_next;
    end
  end

  always_comb begin
    result.scl_level   = scl_reg_next;
    result.sda_level   = sda_reg_next;
    result.sda_drive   = sda_drive_reg_next;
    result.busy        = (phase_next != PH_IDLE);
    result.done        = done;
    result.rx_byte     = received_byte_next;
    result.ack_missing = ack_error_next;
  end

endmodule

// ===== rtl/i2c_bit_level_master_core.sv =====
// Bit-level I2C master sequencer, one input word per clock tick of the bus timing.
// Input channel (in_valid/in_stall): each word carries an optional command
// (cmd_valid, cmd, tx_byte, ack_after_read) and the sampled SDA level sda_in.
// Commands are taken only while idle; while busy, or for unknown codes, they drop.
// Output channel (out_valid/out_stall): one result word per input word, showing the
// pin levels (scl_level, sda_level, sda_drive), busy_res, a done_res pulse, the
// last received rx_byte and the ack_missing flag after that tick.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets ticks per
// delay unit, index 1 the ack timeout; write only while the bus is idle.
// Flow: a word is held in the input register and then stepped into the output
// register, where its result is offered. Throughput: one word per cycle while
// out_stall does not hold the output register; the single-pass step logic from
// the input register to the output register sets that figure.
// Stall: when out_stall holds a full output register, the input register still
// takes one more word; in_stall rises only once both are full.
// Reset (rst, synchronous): bus idle with SCL and SDA driven high, counters and
// flags cleared, delay unit 50 ticks, ack timeout 250 ticks, both stages empty.
`include "assert_macros.svh"

module i2c_bit_level_master_core
  import i2cbm_pkg::*;
#(
  parameter int DELAY_UNIT_WIDTH = DELAY_UNIT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input word channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd_valid,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [DATA_BITS-1:0]  tx_byte,
  input  logic                  ack_after_read,
  input  logic                  sda_in,
  // result word channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  scl_level,
  output logic                  sda_level,
  output logic                  sda_drive,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [DATA_BITS-1:0]  rx_byte,
  output logic                  ack_missing,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_go;
  logic    step_en;
  result_t step_res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  i2cbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage advances whenever the output register is empty or being taken.
  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;
  assign step_en  = s1_valid && s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the word payload; no reset needed.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item.cmd_valid      <= cmd_valid;
      s1_item.cmd            <= cmd;
      s1_item.tx_byte        <= tx_byte;
      s1_item.ack_after_read <= ack_after_read;
      s1_item.sda_in         <= sda_in;
    end
  end

  i2cbm_sequencer #(
    .DELAY_UNIT_WIDTH (DELAY_UNIT_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (step_res)
  );

  // Output register: load a stepped result, clear once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res <= step_res;
    end
  end

  assign scl_level   = out_res.scl_level;
  assign sda_level   = out_res.sda_level;
  assign sda_drive   = out_res.sda_drive;
  assign busy_res    = out_res.busy;
  assign done_res    = out_res.done;
  assign rx_byte     = out_res.rx_byte;
  assign ack_missing = out_res.ack_missing;

  // A finishing command always returns to idle on the same tick.
  `ASSERT_ALWAYS(a_done_not_busy, !(out_valid && done_res && busy_res), "done while busy")
  // SDA is only released with its level parked high.
  `ASSERT_ALWAYS(a_release_high, !(out_valid && !sda_drive && !sda_level), "released SDA low")
  // A blocked input word stays in the input register.
  `ASSERT_IMPLY_NEXT(a_s1_hold, s1_valid && in_stall, s1_valid, "input word lost under stall")

endmodule
